@@ src/ira_pkg.sv @@
// Shared types, constants and glyph function for the integer-to-radix ASCII converter.
// No dependencies.
package ira_pkg;

	localparam int unsigned NUM_W      = 32;
	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned DIGIT_W    = 6;
	localparam int unsigned MAX_DIGITS = 32;
	localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
	localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int unsigned DIV_STEPS  = 8;
	localparam int unsigned DIV_CYCLES = NUM_W / DIV_STEPS;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
	localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

	typedef struct packed {
		logic signed [NUM_W-1:0] number;
		logic [RADIX_W-1:0]      radix;
	} request_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   dividend;
		logic [RADIX_W-1:0] radix;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [NUM_W-1:0]   quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

	// digit 0-35 to '0'-'9','a'-'z'
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
		if (d < DEC_LIMIT)
			glyph = CHAR_ZERO + dx;
		else
			glyph = CHAR_A + dx - {{(CHAR_W - DIGIT_W){1'b0}}, DEC_LIMIT};
	endfunction

endpackage

@@ src/ira_divider.sv @@
// Iterative restoring divider: 32-bit dividend by 6-bit radix, several quotient bits a cycle.
// Depends on ira_pkg.
module ira_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ira_pkg::div_req_t req,
	output ira_pkg::div_rsp_t rsp
);

	logic [ira_pkg::NUM_W-1:0]     quo_q;
	logic [ira_pkg::DIGIT_W-1:0]   rem_q;
	logic [ira_pkg::RADIX_W-1:0]   radix_q;
	logic [ira_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          active_q;
	logic                          done_q;

	logic [ira_pkg::NUM_W-1:0]   quo_nxt;
	logic [ira_pkg::DIGIT_W-1:0] rem_nxt;

	always_comb begin
		logic [ira_pkg::DIGIT_W:0] part;
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int i = 0; i < ira_pkg::DIV_STEPS; i++) begin
			part    = {rem_nxt, quo_nxt[ira_pkg::NUM_W-1]};
			quo_nxt = {quo_nxt[ira_pkg::NUM_W-2:0], 1'b0};
			if (part >= {1'b0, radix_q}) begin
				part       = part - {1'b0, radix_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = part[ira_pkg::DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ira_pkg::DIV_CNT_W'(ira_pkg::DIV_CYCLES - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q   <= req.dividend;
			rem_q   <= '0;
			radix_q <= req.radix;
		end else if (active_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

@@ src/integer_to_radix_ascii.sv @@
// Integer to ASCII text in radix 2..36: sequencer, digit stack and result register.
// Depends on ira_pkg and ira_divider.
// A run divides the magnitude repeatedly, stacking its D digits, then issues one result a cycle
// (optional '-', D digits, NUL). An invalid radix gives only the NUL. Worst case is radix 2, most negative: 32 digits.
// Throughput: one request per run; busy stays high until the NUL is issued.
// Results are strobed for one cycle and cannot be stalled. Reset clears the sequencer and divider control only.
module integer_to_radix_ascii (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ira_pkg::request_t request,
	output logic              result_strobe,
	output ira_pkg::result_t  result
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_SIGN = 5'b00100,
		S_EMIT = 5'b01000,
		S_NUL  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic                            neg_q;
	logic [ira_pkg::RADIX_W-1:0]     radix_q;
	logic [ira_pkg::DIG_CNT_W-1:0]   nd_q;
	logic [ira_pkg::DIGIT_W-1:0]     digit_q [ira_pkg::MAX_DIGITS];
	logic                            strobe_q;
	ira_pkg::result_t                result_q;

	ira_pkg::div_req_t div_req;
	ira_pkg::div_rsp_t div_rsp;

	logic                             accept;
	logic                             radix_ok;
	logic [ira_pkg::NUM_W-1:0]        magnitude;
	logic [ira_pkg::DIG_CNT_W-1:0]    nd_dec;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign radix_ok  = (request.radix >= ira_pkg::RADIX_MIN) &&
	                   (request.radix <= ira_pkg::RADIX_MAX);
	assign magnitude = request.number[ira_pkg::NUM_W-1] ?
	                   (ira_pkg::NUM_W'(0) - ira_pkg::NUM_W'(request.number)) :
	                   ira_pkg::NUM_W'(request.number);
	assign nd_dec    = nd_q - 1'b1;

	always_comb begin
		div_req = '0;
		if (accept) begin
			div_req.start    = radix_ok;
			div_req.dividend = magnitude;
			div_req.radix    = request.radix;
		end else begin
			div_req.start    = (state_q == S_DIV) && div_rsp.done && (div_rsp.quotient != '0);
			div_req.dividend = div_rsp.quotient;
			div_req.radix    = radix_q;
		end
	end

	ira_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			nd_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						nd_q    <= '0;
						state_q <= radix_ok ? S_DIV : S_NUL;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						nd_q <= nd_q + 1'b1;
						if (div_rsp.quotient == '0)
							state_q <= neg_q ? S_SIGN : S_EMIT;
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					nd_q     <= nd_dec;
					if (nd_dec == '0)
						state_q <= S_NUL;
				end
				S_NUL: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= request.number[ira_pkg::NUM_W-1];
			radix_q <= request.radix;
		end
		if ((state_q == S_DIV) && div_rsp.done)
			digit_q[nd_q[ira_pkg::DIG_IDX_W-1:0]] <= div_rsp.remainder;
		case (state_q)
			S_SIGN: begin
				result_q.character <= ira_pkg::CHAR_MINUS;
				result_q.last      <= 1'b0;
			end
			S_EMIT: begin
				result_q.character <= ira_pkg::glyph(digit_q[nd_dec[ira_pkg::DIG_IDX_W-1:0]]);
				result_q.last      <= 1'b0;
			end
			S_NUL: begin
				result_q.character <= ira_pkg::CHAR_NUL;
				result_q.last      <= 1'b1;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	a_nul_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.last == (result.character == ira_pkg::CHAR_NUL)))
		else $error("terminator flag does not match NUL character");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (nd_q != '0))
		else $error("digit emit with empty digit stack");

	a_bad_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !radix_ok) |=> (state_q == S_NUL))
		else $error("invalid radix did not go straight to terminator");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && div_rsp.done) |-> (div_rsp.remainder < radix_q))
		else $error("divider remainder not below radix");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (nd_q < ira_pkg::DIG_CNT_W'(ira_pkg::MAX_DIGITS)))
		else $error("digit count overflow");

endmodule
